// File: design/drbu_pkg.sv
package drbu_pkg;

  localparam int DEFAULT_MAX_WIDTH = 256;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic REG_ROW_WIDTH = 1'b0;

  localparam int ROW_WIDTH_W = 9;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 9'd80;

  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_LAST = 2'd3;

  // utf-8 bytes of a braille code point U+2800 + mask, and newline
  localparam logic [7:0] BYTE_LEAD = 8'hE2;
  localparam logic [7:0] BYTE_MID_BASE = 8'hA0;
  localparam logic [7:0] BYTE_LOW_BASE = 8'h80;
  localparam logic [7:0] BYTE_NL = 8'h0A;

  localparam logic [1:0] IDX_LEAD = 2'd0;
  localparam logic [1:0] IDX_MID = 2'd1;
  localparam logic [1:0] IDX_LOW = 2'd2;
  localparam logic [1:0] IDX_NL = 2'd3;

  // one group of result bytes handed to the byte sequencer
  typedef struct packed {
    logic       has_cell;
    logic       nl;
    logic [7:0] mask;
  } grp_t;

  // left column rows 0..3 -> 0x01 0x02 0x04 0x40, right -> 0x08 0x10 0x20 0x80
  function automatic logic [7:0] cell_mask(input logic [3:0] left, input logic [3:0] right);
    cell_mask = {right[3], left[3], right[2], right[1], right[0], left[2], left[1], left[0]};
  endfunction

endpackage

// File: design/drbu_ifs.sv
interface drbu_in_if;
  logic valid;
  logic ready;
  logic dot;
  logic image_start;

  modport source(output valid, output dot, output image_start, input ready);
  modport sink(input valid, input dot, input image_start, output ready);
endinterface

interface drbu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;

  modport source(output valid, output out_byte, output last_byte, input ready);
  modport sink(input valid, input out_byte, input last_byte, output ready);
endinterface

// File: design/drbu_line_store.sv
module drbu_line_store #(
  parameter int DEPTH = drbu_pkg::DEFAULT_MAX_WIDTH,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [2:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [2:0]    rd_data
);

  logic [2:0] mem [DEPTH];
  logic [2:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/drbu_byte_seq.sv
module drbu_byte_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_valid,
  input  drbu_pkg::grp_t      ld_grp,
  output logic                free,
  drbu_out_if.source          out_ch
);

  logic       v_r, v_nxt;
  logic       cell_r;
  logic       nl_r;
  logic [7:0] mask_r;
  logic [1:0] idx_r, idx_nxt;
  logic       is_last;
  logic       take;
  logic       load;

  always_comb begin
    if (cell_r) begin
      is_last = nl_r ? (idx_r == drbu_pkg::IDX_NL) : (idx_r == drbu_pkg::IDX_LOW);
    end else begin
      is_last = 1'b1;
    end
  end

  always_comb begin
    out_ch.out_byte = drbu_pkg::BYTE_NL;
    if (cell_r) begin
      unique case (idx_r)
        drbu_pkg::IDX_LEAD: out_ch.out_byte = drbu_pkg::BYTE_LEAD;
        drbu_pkg::IDX_MID:  out_ch.out_byte = drbu_pkg::BYTE_MID_BASE | {6'd0, mask_r[7:6]};
        drbu_pkg::IDX_LOW:  out_ch.out_byte = drbu_pkg::BYTE_LOW_BASE | {2'd0, mask_r[5:0]};
        drbu_pkg::IDX_NL:   out_ch.out_byte = drbu_pkg::BYTE_NL;
        default:            out_ch.out_byte = drbu_pkg::BYTE_NL;
      endcase
    end
  end

  assign out_ch.valid = v_r;
  assign out_ch.last_byte = is_last;
  assign take = v_r && out_ch.ready;
  assign free = !v_r || (take && is_last);
  assign load = ld_valid && free;

  always_comb begin
    v_nxt = v_r;
    idx_nxt = idx_r;
    if (load) begin
      v_nxt = 1'b1;
      idx_nxt = drbu_pkg::IDX_LEAD;
    end else if (take) begin
      if (is_last) begin
        v_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
      idx_r <= drbu_pkg::IDX_LEAD;
    end else begin
      v_r <= v_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cell_r <= ld_grp.has_cell;
      nl_r <= ld_grp.nl;
      mask_r <= ld_grp.mask;
    end
  end

  // a newline-only group is a single byte
  a_nl_only_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !cell_r |-> idx_r == drbu_pkg::IDX_LEAD)
    else $error("newline-only group past its first byte");

  a_cell_no_nl_three_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && cell_r && !nl_r |-> idx_r != drbu_pkg::IDX_NL)
    else $error("cell group without newline reached newline slot");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    v_r && !out_ch.ready |=> v_r && $stable(idx_r))
    else $error("pending group dropped while output stalled");

endmodule

// File: design/dot_raster_to_braille_utf8_unit.sv
// latency: a pixel passes through stage 1 and the byte sequencer before its first result byte is offered
// throughput: one pixel per cycle on rows 0..2 of a band; on the fourth row
//   the single output byte port sets the rate: 3 bytes per cell pair plus a
//   newline at row end
// reset: synchronous active-low rst_n clears counters, valid flags and sets
//   row_width to 80; the line store is not cleared and needs no clearing pass
module dot_raster_to_braille_utf8_unit #(
  parameter int MAX_WIDTH = drbu_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  drbu_in_if.sink                     in_ch,
  drbu_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [drbu_pkg::CFG_AW-1:0] paddr,
  input  logic [drbu_pkg::CFG_DW-1:0] pwdata,
  output logic [drbu_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW = (CW + 1 > drbu_pkg::ROW_WIDTH_W) ? CW + 1 : drbu_pkg::ROW_WIDTH_W;

  // configuration
  logic [drbu_pkg::ROW_WIDTH_W-1:0] row_width_r;
  logic                             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == drbu_pkg::REG_ROW_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= drbu_pkg::ROW_WIDTH_RESET;
    end else if (cfg_wr) begin
      row_width_r <= pwdata[drbu_pkg::ROW_WIDTH_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == drbu_pkg::REG_ROW_WIDTH) begin
      prdata = drbu_pkg::CFG_DW'(row_width_r);
    end
  end

  // effective width, clamped to 2..MAX_WIDTH
  logic [EW-1:0] rw_ext;
  logic [EW-1:0] eff_w;

  assign rw_ext = EW'(row_width_r);

  always_comb begin
    priority if (rw_ext < EW'(2)) begin
      eff_w = EW'(2);
    end else if (rw_ext > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = rw_ext;
    end
  end

  // front: position counters
  logic [CW-1:0] col_r;
  logic [1:0]    row_r;
  logic [CW-1:0] c0;
  logic [1:0]    row0;
  logic [EW-1:0] c0_inc;
  logic          last0;
  logic          accept;

  assign c0 = in_ch.image_start ? '0 : col_r;
  assign row0 = in_ch.image_start ? drbu_pkg::ROW_FIRST : row_r;
  assign c0_inc = EW'(c0) + EW'(1);
  assign last0 = (c0_inc >= eff_w);

  // stage 1 holds one pixel with its store entry
  logic          s1_valid_r;
  logic [CW-1:0] s1_addr_r;
  logic [1:0]    s1_row_r;
  logic          s1_dot_r;
  logic          s1_last_r;
  logic          s1_inw_r;
  logic          s1_adv;
  logic          need_grp;
  logic          seq_free;

  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= drbu_pkg::ROW_FIRST;
    end else if (accept) begin
      col_r <= last0 ? '0 : c0_inc[CW-1:0];
      row_r <= last0 ? row0 + 2'd1 : row0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr_r <= c0;
      s1_row_r <= row0;
      s1_dot_r <= in_ch.dot;
      s1_last_r <= last0;
      s1_inw_r <= (EW'(c0) < eff_w);
    end
  end

  // line store with bypass of a write to the address read at the same edge
  logic       st_wr_en;
  logic [2:0] st_wr_data;
  logic [2:0] st_rd_data;
  logic       fwd_r;
  logic [2:0] fwd_data_r;
  logic [2:0] stored;

  drbu_line_store #(
    .DEPTH(MAX_WIDTH),
    .AW(CW)
  ) u_store (
    .clk(clk),
    .wr_en(st_wr_en),
    .wr_addr(s1_addr_r),
    .wr_data(st_wr_data),
    .rd_en(accept),
    .rd_addr(c0),
    .rd_data(st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      fwd_r <= st_wr_en && (s1_addr_r == c0);
      fwd_data_r <= st_wr_data;
    end
  end

  assign stored = fwd_r ? fwd_data_r : st_rd_data;

  always_comb begin
    if (s1_row_r == drbu_pkg::ROW_FIRST) begin
      st_wr_data = {2'b00, s1_dot_r};
    end else begin
      st_wr_data = stored | (3'(s1_dot_r) << s1_row_r);
    end
  end

  assign st_wr_en = s1_adv && (s1_row_r != drbu_pkg::ROW_LAST);

  // fourth row: pair columns into cells
  logic [3:0]     col_dots;
  logic [3:0]     left_r;
  drbu_pkg::grp_t grp;

  assign col_dots = {s1_dot_r, stored};

  always_comb begin
    grp.has_cell = (s1_row_r == drbu_pkg::ROW_LAST) && s1_addr_r[0] && s1_inw_r;
    grp.nl = (s1_row_r == drbu_pkg::ROW_LAST) && s1_last_r;
    grp.mask = drbu_pkg::cell_mask(left_r, col_dots);
  end

  assign need_grp = grp.has_cell || grp.nl;
  assign s1_adv = s1_valid_r && (!need_grp || seq_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (s1_adv && (s1_row_r == drbu_pkg::ROW_LAST) && !s1_addr_r[0]
                 && !s1_last_r) begin
      left_r <= col_dots;
    end
  end

  drbu_byte_seq u_seq (
    .clk(clk),
    .rst_n(rst_n),
    .ld_valid(s1_valid_r && need_grp),
    .ld_grp(grp),
    .free(seq_free),
    .out_ch(out_ch)
  );

  a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> s1_valid_r)
    else $error("accepted pixel missing from stage 1");

  a_col_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(col_r) < EW'(MAX_WIDTH))
    else $error("column counter beyond line store");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(row_r) && $stable(col_r))
    else $error("position moved without a transaction");

endmodule

// File: tb/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXW = drbu_pkg::DEFAULT_MAX_WIDTH;
  localparam int DW = drbu_pkg::CFG_DW;
  localparam int AW = drbu_pkg::CFG_AW;
  localparam int RWW = drbu_pkg::ROW_WIDTH_W;
  localparam int DRAIN_CYC = 8;
  localparam int RAND_ITEMS = 100;

  typedef enum logic {STIM_PIXEL, STIM_CONFIG} stim_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       is_last;
  } beat_t;

  typedef struct {
    stim_kind_t          kind;
    logic [DW-1:0]       value;
    logic                dot;
    logic                start;
    bit                  typed;
    int                  n;
    logic [3:0][7:0]     bytes;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  always #6 clk = ~clk;

  drbu_in_if in_ch();
  drbu_out_if out_ch();

  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  dot_raster_to_braille_utf8_unit DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // braille encoder model state
  logic [2:0]     line_mem [MAXW];
  logic [3:0]     left_dots;
  int             col_pos;
  logic [1:0]     band_row;
  logic [RWW-1:0] width_reg;

  beat_t     pending_bytes[$];
  stim_row_t dir_tab[$];

  int  errors = 0;
  int  pixels_sent = 0;
  int  bytes_checked = 0;
  int  cfg_writes = 0;
  int  rand_items = 0;
  bit  input_calm = 1'b0;

  function automatic int eff_width();
    if (width_reg < 2) return 2;
    if (width_reg > MAXW) return MAXW;
    return int'(width_reg);
  endfunction

  function automatic logic [7:0] dots_to_mask(logic [3:0] l, logic [3:0] r);
    logic [7:0] m;
    m    = '0;
    m[0] = l[0];
    m[1] = l[1];
    m[2] = l[2];
    m[6] = l[3];
    m[3] = r[0];
    m[4] = r[1];
    m[5] = r[2];
    m[7] = r[3];
    return m;
  endfunction

  task automatic encode_pixel(input logic d, input logic s, output int n,
                              output logic [3:0][7:0] b);
    int         eff;
    int         c;
    logic       row_end;
    logic [2:0] stored;
    logic [3:0] colv;
    logic [7:0] m;
    eff = eff_width();
    n = 0;
    b = '0;
    if (s) begin
      col_pos   = 0;
      band_row  = drbu_pkg::ROW_FIRST;
      left_dots = '0;
    end
    c = col_pos;
    row_end = (c + 1 >= eff);
    stored = line_mem[c];
    if (band_row != drbu_pkg::ROW_LAST) begin
      if (band_row == drbu_pkg::ROW_FIRST) line_mem[c] = {2'b00, d};
      else line_mem[c] = stored | (3'(d) << band_row);
    end else begin
      colv = {d, stored};
      if (c % 2 == 0) begin
        if (c + 1 < eff) left_dots = colv;
      end else if (c < eff) begin
        m = dots_to_mask(left_dots, colv);
        b[0] = drbu_pkg::BYTE_LEAD;
        b[1] = drbu_pkg::BYTE_MID_BASE + 8'(m[7:6]);
        b[2] = drbu_pkg::BYTE_LOW_BASE + 8'(m[5:0]);
        n = 3;
      end
      if (row_end) begin
        b[n] = drbu_pkg::BYTE_NL;
        n++;
      end
    end
    if (row_end) begin
      col_pos  = 0;
      band_row = band_row + 2'd1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic stim_row_t pix(logic d, logic s, bit typed = 1'b0, int n = 0,
                                    logic [3:0][7:0] b = '0);
    stim_row_t row;
    row.kind  = STIM_PIXEL;
    row.value = '0;
    row.dot   = d;
    row.start = s;
    row.typed = typed;
    row.n     = n;
    row.bytes = b;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(logic [DW-1:0] v);
    stim_row_t row;
    row       = pix(1'b0, 1'b0);
    row.kind  = STIM_CONFIG;
    row.value = v;
    return row;
  endfunction

  task automatic send_pixel(input logic d, input logic s, input bit typed = 1'b0,
                            input int tn = 0, input logic [3:0][7:0] tbytes = '0);
    int              n;
    int              g;
    logic [3:0][7:0] b;
    in_ch.valid       <= 1'b1;
    in_ch.dot         <= d;
    in_ch.image_start <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    encode_pixel(d, s, n, b);
    if (typed) begin
      n = tn;
      b = tbytes;
    end
    for (int i = 0; i < n; i++) pending_bytes.push_back(beat_t'{b[i], i == n - 1});
    pixels_sent++;
    g = pick_gap();
    if (g > 0 && !input_calm) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_quiet();
    in_ch.valid <= 1'b0;
    wait (pending_bytes.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic read_width(input logic [RWW-1:0] want);
    logic [DW-1:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AW'(4 * drbu_pkg::REG_ROW_WIDTH);
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    rd = prdata;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== DW'(want)) begin
      $display("%0t: row_width readback expected %h got %h", $time, DW'(want), rd);
      errors++;
    end
  endtask

  task automatic write_width(input logic [DW-1:0] v);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AW'(4 * drbu_pkg::REG_ROW_WIDTH);
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    width_reg = v[RWW-1:0];
    cfg_writes++;
    read_width(v[RWW-1:0]);
  endtask

  task automatic stream_pixels(input int count, input int dens, input bit first_start,
                               input bit noise);
    logic d;
    logic s;
    for (int i = 0; i < count; i++) begin
      s = (i == 0 && first_start) || (noise && $urandom_range(0, 59) == 0);
      d = ($urandom_range(0, 99) < dens);
      send_pixel(d, s);
      rand_items++;
    end
  endtask

  function automatic int pick_density();
    case ($urandom_range(0, 2))
      0: return 10;
      1: return 50;
      default: return 90;
    endcase
  endfunction

  // fill part of a band, then shrink the width below the current column
  task automatic shrink_mid_row();
    int w1;
    int w2;
    int r;
    int k;
    int dens;
    w1 = $urandom_range(6, 12);
    dens = pick_density();
    write_width(w1);
    r = $urandom_range(0, 3);
    k = $urandom_range(2, w1 - 1);
    stream_pixels(r * w1 + k, dens, 1'b1, 1'b0);
    wait_quiet();
    w2 = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1) : $urandom_range(2, col_pos);
    write_width(w2);
    stream_pixels((4 - r) * eff_width() + 4 * eff_width() * $urandom_range(0, 1),
                  dens, 1'b0, 1'b1);
  endtask

  task automatic random_phase(input int idx);
    int w;
    int count;
    int dens;
    if ($urandom_range(0, 9) < 2) w = 2 * $urandom_range(1, 6) + 1;
    else w = $urandom_range(2, 12);
    dens = pick_density();
    input_calm = ($urandom_range(0, 4) == 0);
    write_width(w);
    count = $urandom_range(1, 2) * 4 * eff_width() + $urandom_range(0, 1) * $urandom_range(1, 9);
    if (idx == 0) begin
      // hold the pixel stream until every pending byte has drained
      stream_pixels(count / 2, dens, 1'b1, 1'b1);
      wait_quiet();
      stream_pixels(count - count / 2, dens, 1'b0, 1'b1);
    end else begin
      stream_pixels(count, dens, 1'b1, 1'b1);
    end
  endtask

  // output side backpressure
  initial begin
    int g;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      g = pick_gap();
      if (g > 0) begin
        out_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, got byte %h last %b",
                 $time, out_ch.out_byte, out_ch.last_byte);
        errors++;
      end else begin
        want = pending_bytes.pop_front();
        bytes_checked++;
        if (out_ch.out_byte !== want.data || out_ch.last_byte !== want.is_last) begin
          $display("%0t: byte mismatch, expected %h last %b, got %h last %b", $time,
                   want.data, want.is_last, out_ch.out_byte, out_ch.last_byte);
          errors++;
        end
      end
    end
  end

  initial begin
    #40_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [6:0] pattern;
    int         shorts[3];
    in_ch.valid       <= 1'b0;
    in_ch.dot         <= 1'b0;
    in_ch.image_start <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_n   <= 1'b0;
    foreach (line_mem[i]) line_mem[i] = '0;
    left_dots = '0;
    col_pos   = 0;
    band_row  = drbu_pkg::ROW_FIRST;
    width_reg = drbu_pkg::ROW_WIDTH_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_width(drbu_pkg::ROW_WIDTH_RESET);

    // directed: all-set and all-blank cells at the narrowest width
    dir_tab.push_back(cfg_row(2));
    dir_tab.push_back(pix(1'b1, 1'b1, 1'b1, 0));
    repeat (6) dir_tab.push_back(pix(1'b1, 1'b0, 1'b1, 0));
    dir_tab.push_back(pix(1'b1, 1'b0, 1'b1, 4,
                          {drbu_pkg::BYTE_NL, 8'hBF, 8'hA3, drbu_pkg::BYTE_LEAD}));
    repeat (7) dir_tab.push_back(pix(1'b0, 1'b0, 1'b1, 0));
    dir_tab.push_back(pix(1'b0, 1'b0, 1'b1, 4,
                          {drbu_pkg::BYTE_NL, 8'h80, 8'hA0, drbu_pkg::BYTE_LEAD}));
    // width below range, image restart in the middle of a band
    dir_tab.push_back(cfg_row(0));
    dir_tab.push_back(pix(1'b1, 1'b1));
    dir_tab.push_back(pix(1'b0, 1'b0));
    dir_tab.push_back(pix(1'b1, 1'b0));
    dir_tab.push_back(pix(1'b1, 1'b1));
    pattern = 7'b1100110;
    for (int i = 0; i < 7; i++) dir_tab.push_back(pix(pattern[i], 1'b0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == STIM_CONFIG) write_width(dir_tab[i].value);
      else send_pixel(dir_tab[i].dot, dir_tab[i].start, dir_tab[i].typed,
                      dir_tab[i].n, dir_tab[i].bytes);
    end

    // width 1 acts as 2, odd width 3
    write_width(1);
    stream_pixels(16, 50, 1'b1, 1'b0);
    write_width(3);
    stream_pixels(24, 50, 1'b1, 1'b0);
    // widths at and above the store size, only a partial row each
    shorts = '{256, 257, 511};
    foreach (shorts[i]) begin
      write_width(shorts[i]);
      stream_pixels($urandom_range(10, 40), 50, 1'b1, 1'b0);
    end

    rand_items = 0;
    for (int p = 0; rand_items < RAND_ITEMS; p++) begin
      if (p % 4 == 1) shrink_mid_row();
      else random_phase(p);
    end
    input_calm = 1'b0;

    wait_quiet();
    repeat (20) @(posedge clk);
    $display("sent %0d pixels over %0d row_width writes, checked %0d result bytes",
             pixels_sent, cfg_writes, bytes_checked);
    $display("covered width extremes, odd widths, image restarts and mid-row shrinks");
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

// File: sim.f
design/drbu_pkg.sv
design/drbu_ifs.sv
design/drbu_line_store.sv
design/drbu_byte_seq.sv
design/dot_raster_to_braille_utf8_unit.sv
tb/tb_top.sv
